// ===== hdl/ohp_pkg.sv =====
// Shared types and constants for the OBEX header stream parser.
// No dependencies; the parser, the top level and both bench files import this package.
package ohp_pkg;

  localparam int unsigned DataW     = 8;
  localparam int unsigned LenW      = 16;
  localparam int unsigned FormShift = 6;
  localparam int unsigned PrefixLen = 3;
  localparam int unsigned Form3Len  = 4;

  localparam logic [1:0] PH_TAG    = 2'd0;
  localparam logic [1:0] PH_LEN_HI = 2'd1;
  localparam logic [1:0] PH_LEN_LO = 2'd2;
  localparam logic [1:0] PH_VALUE  = 2'd3;

  localparam logic [1:0] FORM_LEN0 = 2'd0;
  localparam logic [1:0] FORM_LEN1 = 2'd1;
  localparam logic [1:0] FORM_BYTE = 2'd2;
  localparam logic [1:0] FORM_QUAD = 2'd3;

  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic             skip_byte;
    logic             buffer_end;
  } ohp_item_t;

  typedef struct packed {
    logic             value_valid;
    logic [DataW-1:0] header_tag;
    logic [DataW-1:0] value_data;
    logic             value_last;
    logic             empty_header;
    logic             parse_error;
    logic             buffer_done;
    logic             buffer_ok;
  } ohp_result_t;

endpackage

// ===== hdl/ohp_in_if.sv =====
// Input byte channel of the OBEX header stream parser.
// Depends on nothing; carries valid, ready and one buffer byte with its marks.
interface ohp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       skip_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output skip_byte, output buffer_end,
                  input ready);
  modport sink (input valid, input data_byte, input skip_byte, input buffer_end,
                output ready);
endinterface

// ===== hdl/ohp_out_if.sv =====
// Result channel of the OBEX header stream parser.
// Depends on nothing; carries valid, ready and one parse result per input byte.
interface ohp_out_if;
  logic       valid;
  logic       ready;
  logic       value_valid;
  logic [7:0] header_tag;
  logic [7:0] value_data;
  logic       value_last;
  logic       empty_header;
  logic       parse_error;
  logic       buffer_done;
  logic       buffer_ok;

  modport source (output valid, output value_valid, output header_tag, output value_data,
                  output value_last, output empty_header, output parse_error,
                  output buffer_done, output buffer_ok, input ready);
  modport sink (input valid, input value_valid, input header_tag, input value_data,
                input value_last, input empty_header, input parse_error,
                input buffer_done, input buffer_ok, output ready);
endinterface

// ===== hdl/ohp_parser.sv =====
// Parse state and per-byte next-state logic of the OBEX header stream parser.
// Depends on ohp_pkg for the item and result types and the phase codes.
module ohp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  ohp_pkg::ohp_item_t  item,
  output ohp_pkg::ohp_result_t result
);
  import ohp_pkg::*;

  logic [1:0]       phase_r,   phase_nxt;
  logic [DataW-1:0] tag_r,     tag_nxt;
  logic [DataW-1:0] len_hi_r,  len_hi_nxt;
  logic [LenW-1:0]  remain_r,  remain_nxt;
  logic             err_seen_r, err_seen_nxt;

  logic [LenW-1:0]  len_full;
  logic [LenW-1:0]  remain_dec;
  logic [1:0]       form;

  assign len_full   = {len_hi_r, item.data_byte};
  assign remain_dec = remain_r - LenW'(1);
  assign form       = item.data_byte[FormShift +: 2];

  always_comb begin
    phase_nxt    = phase_r;
    tag_nxt      = tag_r;
    len_hi_nxt   = len_hi_r;
    remain_nxt   = remain_r;
    err_seen_nxt = err_seen_r;
    result       = '0;

    if (!item.skip_byte && !err_seen_r) begin
      unique case (phase_r)
        PH_TAG: begin
          tag_nxt = item.data_byte;
          case (form) inside
            FORM_LEN0, FORM_LEN1: phase_nxt = PH_LEN_HI;
            FORM_BYTE: begin
              remain_nxt = LenW'(1);
              phase_nxt  = PH_VALUE;
            end
            default: begin
              remain_nxt = LenW'(Form3Len);
              phase_nxt  = PH_VALUE;
            end
          endcase
        end
        PH_LEN_HI: begin
          len_hi_nxt = item.data_byte;
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (len_full < LenW'(PrefixLen)) begin
            result.parse_error = 1'b1;
            err_seen_nxt       = 1'b1;
            phase_nxt          = PH_TAG;
          end else if (len_full == LenW'(PrefixLen)) begin
            result.empty_header = 1'b1;
            phase_nxt           = PH_TAG;
          end else begin
            remain_nxt = len_full - LenW'(PrefixLen);
            phase_nxt  = PH_VALUE;
          end
        end
        default: begin
          result.value_valid = 1'b1;
          result.value_data  = item.data_byte;
          remain_nxt         = remain_dec;
          if (remain_dec == '0) begin
            result.value_last = 1'b1;
            phase_nxt         = PH_TAG;
          end
        end
      endcase
    end

    result.header_tag = tag_nxt;

    if (item.buffer_end) begin
      result.buffer_done = 1'b1;
      if (!err_seen_nxt && phase_nxt != PH_TAG) begin
        result.parse_error = 1'b1;
        err_seen_nxt       = 1'b1;
      end
      result.buffer_ok = !err_seen_nxt;
      phase_nxt        = PH_TAG;
      tag_nxt          = '0;
      len_hi_nxt       = '0;
      remain_nxt       = '0;
      err_seen_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TAG;
      tag_r      <= '0;
      len_hi_r   <= '0;
      remain_r   <= '0;
      err_seen_r <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      tag_r      <= tag_nxt;
      len_hi_r   <= len_hi_nxt;
      remain_r   <= remain_nxt;
      err_seen_r <= err_seen_nxt;
    end
  end

endmodule

// ===== hdl/obex_header_stream_parser.sv =====
// Top level of the OBEX header stream parser: input register, parser, result register.
// Depends on ohp_pkg, ohp_in_if, ohp_out_if and ohp_parser.
//
//   Channel   Modport   Request carries
//   in_chan   sink      data_byte, skip_byte, buffer_end
//   out_chan  source    value_valid, header_tag, value_data, value_last,
//                       empty_header, parse_error, buffer_done, buffer_ok
//
// Every accepted request yields exactly one result, passed from the input register to the result register.
// One request is taken per cycle while the result side does not stall; the parse state updates as a request moves
// from the input register into the result register.
// A stalled result register holds the input register, and ready drops only when both are full.
// Synchronous active-low reset empties both registers and clears the parse state.
module obex_header_stream_parser (
  input logic clk,
  input logic rst_n,
  ohp_in_if.sink    in_chan,
  ohp_out_if.source out_chan
);
  import ohp_pkg::*;

  logic        in_v_r;
  ohp_item_t   in_item_r;
  logic        out_v_r;
  ohp_result_t out_res_r;
  ohp_result_t res_nxt;
  logic        advance;
  logic        step;

  assign advance       = !out_v_r || out_chan.ready;
  assign step          = in_v_r && advance;
  assign in_chan.ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_item_r <= '{data_byte:  in_chan.data_byte,
                     skip_byte:  in_chan.skip_byte,
                     buffer_end: in_chan.buffer_end};
    end
  end

  ohp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .result (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.value_valid  = out_res_r.value_valid;
  assign out_chan.header_tag   = out_res_r.header_tag;
  assign out_chan.value_data   = out_res_r.value_data;
  assign out_chan.value_last   = out_res_r.value_last;
  assign out_chan.empty_header = out_res_r.empty_header;
  assign out_chan.parse_error  = out_res_r.parse_error;
  assign out_chan.buffer_done  = out_res_r.buffer_done;
  assign out_chan.buffer_ok    = out_res_r.buffer_ok;

  a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.buffer_ok |-> out_res_r.buffer_done && !out_res_r.parse_error)
    else $error("buffer_ok without buffer_done or with parse_error");

  a_last_needs_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.value_last |-> out_res_r.value_valid && !out_res_r.empty_header)
    else $error("value_last without a value byte");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_v_r)
    else $error("parsed request did not reach the result register");

  a_stall_holds_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !advance |=> in_v_r && $stable(in_item_r))
    else $error("input register changed while the result side stalled");

endmodule

// ===== bench/ohp_tb_pkg.sv =====
// Header tracker for the OBEX header stream parser bench: it predicts the result of
// every request and checks the results the parser delivers. Depends on ohp_pkg.
package ohp_tb_pkg;
  import ohp_pkg::*;

  class ohp_header_tracker;
    logic [1:0]      phase;
    logic [7:0]      tag;
    logic [7:0]      len_high;
    logic [15:0]     remaining;
    bit              err_seen;
    ohp_result_t     owed_results[$];
    int unsigned     fail_count;
    int unsigned     byte_count;
    int unsigned     value_bytes;
    int unsigned     empty_count;
    int unsigned     error_count;
    int unsigned     frames_done;
    int unsigned     frames_clean;

    function new();
      clear_parse();
      fail_count   = 0;
      byte_count   = 0;
      value_bytes  = 0;
      empty_count  = 0;
      error_count  = 0;
      frames_done  = 0;
      frames_clean = 0;
    endfunction

    function void clear_parse();
      phase     = PH_TAG;
      tag       = '0;
      len_high  = '0;
      remaining = '0;
      err_seen  = 1'b0;
    endfunction

    function void take_byte(ohp_item_t req);
      ohp_result_t r;
      logic [15:0] hdr_len;
      logic [7:0]  shifted;
      logic [1:0]  form;
      r = '0;
      byte_count++;
      if (!req.skip_byte && !err_seen) begin
        case (phase)
          PH_TAG: begin
            tag     = req.data_byte;
            shifted = req.data_byte >> FormShift;
            form    = shifted[1:0];
            if (form == FORM_LEN0 || form == FORM_LEN1) begin
              phase = PH_LEN_HI;
            end else begin
              remaining = (form == FORM_BYTE) ? 16'd1 : 16'(Form3Len);
              phase     = PH_VALUE;
            end
          end
          PH_LEN_HI: begin
            len_high = req.data_byte;
            phase    = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            hdr_len = {len_high, req.data_byte};
            if (hdr_len < 16'(PrefixLen)) begin
              r.parse_error = 1'b1;
              err_seen      = 1'b1;
              phase         = PH_TAG;
            end else if (hdr_len == 16'(PrefixLen)) begin
              r.empty_header = 1'b1;
              phase          = PH_TAG;
            end else begin
              remaining = hdr_len - 16'(PrefixLen);
              phase     = PH_VALUE;
            end
          end
          default: begin
            r.value_valid = 1'b1;
            r.value_data  = req.data_byte;
            remaining     = remaining - 16'd1;
            if (remaining == 16'd0) begin
              r.value_last = 1'b1;
              phase        = PH_TAG;
            end
          end
        endcase
      end
      r.header_tag = tag;
      if (req.buffer_end) begin
        r.buffer_done = 1'b1;
        if (!err_seen && phase != PH_TAG) begin
          r.parse_error = 1'b1;
          err_seen      = 1'b1;
        end
        r.buffer_ok = !err_seen;
        frames_done++;
        if (!err_seen) frames_clean++;
        clear_parse();
      end
      if (r.value_valid) value_bytes++;
      if (r.empty_header) empty_count++;
      if (r.parse_error) error_count++;
      owed_results = {owed_results, r};
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(ohp_result_t got);
      ohp_result_t want;
      if (owed_results.size() == 0) begin
        $error("result arrived with no request outstanding: %0h", got);
        fail_count++;
        return;
      end
      want = owed_results.pop_front();
      check_field("value_valid", 8'(want.value_valid), 8'(got.value_valid));
      check_field("header_tag", want.header_tag, got.header_tag);
      check_field("value_data", want.value_data, got.value_data);
      check_field("value_last", 8'(want.value_last), 8'(got.value_last));
      check_field("empty_header", 8'(want.empty_header), 8'(got.empty_header));
      check_field("parse_error", 8'(want.parse_error), 8'(got.parse_error));
      check_field("buffer_done", 8'(want.buffer_done), 8'(got.buffer_done));
      check_field("buffer_ok", 8'(want.buffer_ok), 8'(got.buffer_ok));
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction
  endclass

endpackage

// ===== bench/obex_header_stream_parser_tb.sv =====
// Top-level bench for obex_header_stream_parser: drives directed and random buffers
// with random idling on both channels. Depends on ohp_pkg, the two channel interfaces,
// the parser RTL and ohp_tb_pkg.
module obex_header_stream_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ohp_pkg::*;
  import ohp_tb_pkg::*;

  localparam int unsigned RandomBytes = 1150;
  localparam int unsigned QuietFrom   = 1000;

  logic clk = 1'b0;
  logic rst_n;

  ohp_in_if  in_chan ();
  ohp_out_if out_chan ();

  obex_header_stream_parser DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  ohp_header_tracker tracker;
  ohp_item_t         frame_q[$];
  bit                gaps_on;
  bit                stalls_on;
  bit                long_hold_req;
  int unsigned       sent_total;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    #2_000_000;
    $display("obex_header_stream_parser regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_chan.valid && in_chan.ready) begin
        tracker.take_byte({in_chan.data_byte, in_chan.skip_byte, in_chan.buffer_end});
      end
      if (out_chan.valid && out_chan.ready) begin
        tracker.check_result({out_chan.value_valid, out_chan.header_tag, out_chan.value_data,
                              out_chan.value_last, out_chan.empty_header,
                              out_chan.parse_error, out_chan.buffer_done,
                              out_chan.buffer_ok});
      end
    end
  end

  initial begin : result_sink
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        out_chan.ready = 1'b0;
        repeat (64) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_chan.ready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        out_chan.ready = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic skip, input logic last);
    in_chan.valid      = 1'b1;
    in_chan.data_byte  = b;
    in_chan.skip_byte  = skip;
    in_chan.buffer_end = last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent_total++;
    @(negedge clk);
  endtask

  task automatic hold_input_idle(input int unsigned cycles);
    in_chan.valid      = 1'b0;
    in_chan.data_byte  = 8'($urandom);
    in_chan.skip_byte  = 1'($urandom);
    in_chan.buffer_end = 1'($urandom);
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_drained();
    hold_input_idle(1);
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  function automatic void add_req(input logic [7:0] b, input logic skip);
    ohp_item_t it;
    it.data_byte  = b;
    it.skip_byte  = skip;
    it.buffer_end = 1'b0;
    frame_q = {frame_q, it};
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    if ($urandom_range(0, 19) == 0) add_req(8'($urandom), 1'b1);
    add_req(b, 1'b0);
  endfunction

  // Mostly well-formed buffers with random content; some are noise, truncated,
  // or carry bad lengths.
  task automatic build_frame();
    int unsigned hdr_len;
    int unsigned n_val;
    int unsigned keep;
    logic [1:0]  form;
    logic [5:0]  tag_low;
    frame_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) add_req(8'($urandom), $urandom_range(0, 3) == 0);
    end else begin
      repeat ($urandom_range(0, 3)) add_req(8'($urandom), 1'b1);
      repeat ($urandom_range(0, 4)) begin
        form    = 2'($urandom_range(0, 3));
        tag_low = 6'($urandom);
        add_byte({form, tag_low});
        if (form == FORM_LEN0 || form == FORM_LEN1) begin
          case ($urandom_range(0, 31)) inside
            0:       hdr_len = $urandom_range(0, PrefixLen - 1);
            1:       hdr_len = $urandom_range(0, 65535);
            2, 3:    hdr_len = PrefixLen + $urandom_range(9, 48);
            default: hdr_len = PrefixLen + $urandom_range(0, 8);
          endcase
          add_byte(hdr_len[15:8]);
          add_byte(hdr_len[7:0]);
          n_val = (hdr_len > PrefixLen) ? hdr_len - PrefixLen : 0;
        end else begin
          n_val = (form == FORM_BYTE) ? 1 : Form3Len;
        end
        if (n_val > 64) n_val = $urandom_range(0, 64);
        repeat (n_val) add_byte(8'($urandom));
      end
      if (frame_q.size() == 0 || $urandom_range(0, 15) == 0) begin
        add_req(8'($urandom), 1'b1);
      end else if ($urandom_range(0, 7) == 0) begin
        keep    = $urandom_range(0, frame_q.size() - 1);
        frame_q = frame_q[0:keep];
      end
    end
    frame_q[frame_q.size() - 1].buffer_end = 1'b1;
  endtask

  task automatic send_frame(input bit with_gaps);
    foreach (frame_q[i]) begin
      if (with_gaps && $urandom_range(0, 5) == 0) hold_input_idle($urandom_range(1, 16));
      send_byte(frame_q[i].data_byte, frame_q[i].skip_byte, frame_q[i].buffer_end);
    end
  endtask

  initial begin : stimulus
    bit hold_done;
    bit pause_done;
    hold_done          = 1'b0;
    pause_done         = 1'b0;
    tracker            = new();
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.data_byte  = '0;
    in_chan.skip_byte  = 1'b0;
    in_chan.buffer_end = 1'b0;
    gaps_on            = 1'b0;
    stalls_on          = 1'b0;
    long_hold_req      = 1'b0;
    sent_total         = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // A clean buffer with a skip prefix, a skip inside a header, every value form
    // and an empty header; the last value byte also ends the buffer.
    send_byte(8'hA5, 1'b1, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h02, 1'b0, 1'b0);
    send_byte(8'h03, 1'b0, 1'b0);
    send_byte(8'h04, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h03, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h05, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b0);
    send_byte(8'h55, 1'b0, 1'b1);
    // A length under the prefix size, then bytes that must be ignored.
    send_byte(8'h48, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h02, 1'b0, 1'b0);
    send_byte(8'hC0, 1'b0, 1'b0);
    send_byte(8'h12, 1'b0, 1'b1);
    // A truncated header whose buffer ends on a skip byte.
    send_byte(8'h49, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h11, 1'b1, 1'b1);
    wait_drained();

    while (sent_total < RandomBytes) begin
      if (sent_total >= QuietFrom) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else begin
        gaps_on   = (sent_total / 150) % 3 != 2;
        stalls_on = (sent_total / 110) % 3 != 1;
      end
      if (!hold_done && sent_total >= 400) begin
        hold_done     = 1'b1;
        long_hold_req = 1'b1;
        while (long_hold_req) begin
          build_frame();
          send_frame(1'b0);
        end
      end
      if (!pause_done && sent_total >= 750) begin
        pause_done = 1'b1;
        wait_drained();
      end
      build_frame();
      send_frame(gaps_on);
    end

    wait_drained();
    repeat (8) @(negedge clk);
    $display("Run covered %0d requests in %0d buffers (%0d clean): %0d value bytes,",
             tracker.byte_count, tracker.frames_done, tracker.frames_clean,
             tracker.value_bytes);
    $display("%0d empty headers and %0d parse errors, with long result stalls.",
             tracker.empty_count, tracker.error_count);
    if (tracker.fail_count == 0) begin
      $display("obex_header_stream_parser regression: pass");
    end else begin
      $display("obex_header_stream_parser regression: fail");
    end
    $finish;
  end

endmodule
